### rtl/comment_string_lexer_defines.svh
// Assertion macros for the comment/string lexer.
`ifndef COMMENT_STRING_LEXER_DEFINES_SVH
`define COMMENT_STRING_LEXER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define CSL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
// Checked during reset as well.
`define CSL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");
`else
`define CSL_ASSERT(lbl, clk, rst_n, prop)
`define CSL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/cslex_pkg.sv
package cslex_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned StateW = 5;
    localparam int unsigned ClassW = 4;

    localparam logic [ByteW-1:0] CH_SLASH  = 8'h2F;
    localparam logic [ByteW-1:0] CH_STAR   = 8'h2A;
    localparam logic [ByteW-1:0] CH_NL     = 8'h0A;
    localparam logic [ByteW-1:0] CH_DQ     = 8'h22;
    localparam logic [ByteW-1:0] CH_SQ     = 8'h27;
    localparam logic [ByteW-1:0] CH_BT     = 8'h60;
    localparam logic [ByteW-1:0] CH_ESC    = 8'h5C;
    localparam logic [ByteW-1:0] CH_HASH   = 8'h23;
    localparam logic [ByteW-1:0] CH_USCORE = 8'h5F;
    localparam logic [ByteW-1:0] CH_LBRACE = 8'h7B;
    localparam logic [ByteW-1:0] CH_RBRACE = 8'h7D;
    localparam logic [ByteW-1:0] CH_LPAREN = 8'h28;
    localparam logic [ByteW-1:0] CH_RPAREN = 8'h29;
    localparam logic [ByteW-1:0] CH_SEMI   = 8'h3B;
    localparam logic [ByteW-1:0] CH_COMMA  = 8'h2C;

    typedef enum logic [ClassW-1:0] {
        CLS_SLASH = 4'd0,
        CLS_STAR  = 4'd1,
        CLS_NL    = 4'd2,
        CLS_DQ    = 4'd3,
        CLS_SQ    = 4'd4,
        CLS_BT    = 4'd5,
        CLS_ESC   = 4'd6,
        CLS_WORD  = 4'd7,
        CLS_MISC  = 4'd8,
        CLS_OTHER = 4'd9
    } byte_class_t;

    typedef enum logic [StateW-1:0] {
        ST_START     = 5'd0,
        ST_SLASH     = 5'd1,
        ST_LINE      = 5'd2,
        ST_BLK_OPEN  = 5'd3,
        ST_DOC_MAYBE = 5'd4,
        ST_DOC       = 5'd5,
        ST_DOC_STAR  = 5'd6,
        ST_BLK       = 5'd7,
        ST_BLK_STAR  = 5'd8,
        ST_WORD      = 5'd9,
        ST_DQ        = 5'd10,
        ST_DQ_ESC    = 5'd11,
        ST_SQ        = 5'd12,
        ST_SQ_ESC    = 5'd13,
        ST_BT        = 5'd14,
        ST_BT_ESC    = 5'd15,
        ST_OTHER     = 5'd16
    } lex_state_t;

    typedef struct packed {
        lex_state_t state;
        logic       accepting;
    } step_result_t;

endpackage

### rtl/comment_string_lexer.sv
// Comment and string lexer.
// Input channel: text_byte, end_of_text with in_valid/in_ready, one byte per item.
// Output channel: lex_state, byte_class, accepting, final_item with
// out_valid/out_ready, one result per input item.
// Path: an accepted item is held in the input register, then classify and
// next-state logic load the result register, which drives out_valid.
// Throughput: 1 item per cycle while out_ready holds; the state register feeds
// back in the same cycle it is updated, so consecutive bytes need no bubbles.
// Reset: lexical state returns to start, both registers empty.
// end_of_text does not reset the state; a new text continues from where the
// last one stopped unless the block is reset.
// Stall: a held result keeps its register; one more item waits in the input
// register, after which in_ready drops until out_ready returns.
`include "comment_string_lexer_defines.svh"

module comment_string_lexer
    import cslex_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ByteW-1:0]  text_byte,
    input  logic              end_of_text,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [StateW-1:0] lex_state,
    output logic [ClassW-1:0] byte_class,
    output logic              accepting,
    output logic              final_item
);

    logic             in_valid_reg;
    logic [ByteW-1:0] byte_reg;
    logic             eot_reg;

    logic             out_valid_reg;
    lex_state_t       lex_state_reg;
    byte_class_t      class_reg;
    logic             accepting_reg;
    logic             final_reg;

    logic             advance;
    byte_class_t      cls;
    lex_state_t       cur_state;
    step_result_t     step;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= text_byte;
            eot_reg  <= end_of_text;
        end
    end

    cslex_classify u_classify (
        .text_byte  (byte_reg),
        .byte_class (cls)
    );

    cslex_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .byte_class (cls),
        .state      (cur_state),
        .result     (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lex_state_reg <= step.state;
            class_reg     <= cls;
            accepting_reg <= step.accepting;
            final_reg     <= eot_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign lex_state  = lex_state_reg;
    assign byte_class = class_reg;
    assign accepting  = accepting_reg;
    assign final_item = final_reg;

    `CSL_ASSERT(a_stall_blocks_input, clk, rst_n,
        in_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
    `CSL_ASSERT(a_state_tracks_output, clk, rst_n,
        out_valid_reg |-> cur_state == lex_state_reg)
    `CSL_ASSERT(a_result_loaded, clk, rst_n,
        advance |=> out_valid_reg && lex_state_reg == $past(step.state))
    `CSL_ASSERT(a_accepting_matches, clk, rst_n,
        out_valid_reg |-> accepting_reg == ((lex_state_reg == ST_START) ||
            (lex_state_reg == ST_WORD) || (lex_state_reg == ST_OTHER)))
    `CSL_ASSERT_ALWAYS(a_reset_empty, clk,
        !rst_n |-> !out_valid_reg && !in_valid_reg && cur_state == ST_START)

endmodule

### rtl/cslex_classify.sv
module cslex_classify
    import cslex_pkg::*;
(
    input  logic [ByteW-1:0] text_byte,
    output byte_class_t      byte_class
);

    always_comb
    begin
        case (text_byte) inside
            CH_SLASH:                    byte_class = CLS_SLASH;
            CH_STAR:                     byte_class = CLS_STAR;
            CH_NL:                       byte_class = CLS_NL;
            CH_DQ:                       byte_class = CLS_DQ;
            CH_SQ:                       byte_class = CLS_SQ;
            CH_BT:                       byte_class = CLS_BT;
            CH_ESC:                      byte_class = CLS_ESC;
            CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_SEMI, CH_COMMA:
                                         byte_class = CLS_MISC;
            [8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], CH_USCORE, CH_HASH:
                                         byte_class = CLS_WORD;
            default:                     byte_class = CLS_OTHER;
        endcase
    end

endmodule

### rtl/cslex_step.sv
module cslex_step
    import cslex_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  byte_class_t  byte_class,
    output lex_state_t   state,
    output step_result_t result
);

    lex_state_t state_reg;
    lex_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_START, ST_SLASH, ST_WORD, ST_OTHER:
            begin
                unique case (byte_class)
                    CLS_SLASH: state_next = (state_reg == ST_SLASH) ? ST_LINE : ST_SLASH;
                    CLS_STAR:  state_next = (state_reg == ST_SLASH) ? ST_BLK_OPEN : ST_OTHER;
                    CLS_NL:    state_next = ST_START;
                    CLS_DQ:    state_next = ST_DQ;
                    CLS_SQ:    state_next = ST_SQ;
                    CLS_BT:    state_next = ST_BT;
                    CLS_WORD:  state_next = ST_WORD;
                    CLS_MISC:  state_next = ST_START;
                    default:   state_next = ST_OTHER;
                endcase
            end
            ST_LINE:      state_next = (byte_class == CLS_NL) ? ST_START : ST_LINE;
            ST_BLK_OPEN:  state_next = (byte_class == CLS_STAR) ? ST_DOC_MAYBE : ST_BLK;
            ST_BLK:       state_next = (byte_class == CLS_STAR) ? ST_BLK_STAR : ST_BLK;
            ST_BLK_STAR:
            begin
                if (byte_class == CLS_SLASH)
                    state_next = ST_START;
                else
                    state_next = (byte_class == CLS_STAR) ? ST_BLK_STAR : ST_BLK;
            end
            ST_DOC_MAYBE: state_next = (byte_class == CLS_SLASH) ? ST_START : ST_DOC;
            ST_DOC:       state_next = (byte_class == CLS_STAR) ? ST_DOC_STAR : ST_DOC;
            ST_DOC_STAR:
            begin
                if (byte_class == CLS_SLASH)
                    state_next = ST_START;
                else
                    state_next = (byte_class == CLS_STAR) ? ST_DOC_STAR : ST_DOC;
            end
            ST_DQ:
            begin
                if (byte_class == CLS_NL || byte_class == CLS_DQ)
                    state_next = ST_START;
                else
                    state_next = (byte_class == CLS_ESC) ? ST_DQ_ESC : ST_DQ;
            end
            ST_DQ_ESC:    state_next = ST_DQ;
            ST_SQ:
            begin
                if (byte_class == CLS_NL || byte_class == CLS_SQ)
                    state_next = ST_START;
                else
                    state_next = (byte_class == CLS_ESC) ? ST_SQ_ESC : ST_SQ;
            end
            ST_SQ_ESC:    state_next = ST_SQ;
            ST_BT:
            begin
                // backtick string closes on an apostrophe
                if (byte_class == CLS_NL || byte_class == CLS_SQ)
                    state_next = ST_START;
                else
                    state_next = (byte_class == CLS_ESC) ? ST_BT_ESC : ST_BT;
            end
            ST_BT_ESC:    state_next = ST_BT;
            default:      state_next = ST_START;
        endcase
    end

    always_comb
    begin
        result.state     = state_next;
        result.accepting = (state_next == ST_START) || (state_next == ST_WORD) ||
                           (state_next == ST_OTHER);
    end

    assign state = state_reg;

endmodule
